// File: rtl/msi_pkg.sv
// Package with shared codes and widths for the sample interpolator.
package msi_pkg;
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_PUSH  = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam int unsigned IDX_W = 7;
   localparam int unsigned JNT_W = 4;
   localparam int unsigned FRAC_W = 16;
endpackage

// File: rtl/msi_lerp.sv
// Lerp unit: registered difference times the fraction, plus the base value.
module msi_lerp
   import msi_pkg::*;
(
   input  logic                     clock,
   input  logic signed [31:0]       a_val,
   input  logic signed [31:0]       b_val,
   input  logic [FRAC_W-1:0]        frac,
   output logic signed [31:0]       result
);
   logic signed [32:0] diff_ff;
   logic signed [31:0] base_ff;
   logic [FRAC_W-1:0]  frac_ff;
   logic signed [49:0] prod;

   // First stage registers the difference; second stage multiplies and adds.
   always_ff @(posedge clock) begin
      diff_ff <= 33'(b_val) - 33'(a_val);
      base_ff <= a_val;
      frac_ff <= frac;
   end

   // Arithmetic shift floors toward minus infinity, as required.
   assign prod   = 50'(diff_ff) * $signed({34'd0, frac_ff});
   assign result = base_ff + 32'(prod >>> FRAC_W);
endmodule

// File: rtl/multi_channel_sample_interpolator.sv
// Top level of the multi-channel sample interpolator.
// Clear and push words are taken in idle when no word is pending; a push that drops a record
// gives one word. A lerp query reads the first and last stamps, checks the start stamp,
// searches forward, runs the divider and then reads, interpolates and returns each joint.
// Queries outside the stamp range skip search and divider.
// Synchronous active-high reset empties the table; stored values are not cleared.
module multi_channel_sample_interpolator
   import msi_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int JOINTS = 12
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_func,
   input  logic [31:0]          req_stamp,
   input  logic [JNT_W-1:0]     req_joint,
   input  logic signed [31:0]   req_angle_in,
   input  logic signed [31:0]   req_velocity_in,
   input  logic signed [31:0]   req_force_in,
   input  logic [IDX_W-1:0]     req_start_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [JNT_W-1:0]     rsp_joint_out,
   output logic signed [31:0]   rsp_angle_out,
   output logic signed [31:0]   rsp_velocity_out,
   output logic signed [31:0]   rsp_force_out,
   output logic [IDX_W-1:0]     rsp_next_index,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SD = TABLE_DEPTH * JOINTS;
   localparam int SW = $clog2(SD);
   localparam int JW = $clog2(JOINTS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_T0    = 4'd1;
   localparam logic [3:0] S_TLAST = 4'd2;
   localparam logic [3:0] S_TLO   = 4'd3;
   localparam logic [3:0] S_SRCH  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_RDA   = 4'd6;
   localparam logic [3:0] S_RDB   = 4'd7;
   localparam logic [3:0] S_MUL   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_WAIT  = 4'd10;
   localparam logic [3:0] S_RES   = 4'd11;
   localparam logic [3:0] S_TREQ  = 4'd12;

   // Storage for stamps and per-joint samples.
   logic [31:0] time_mem [TABLE_DEPTH];
   logic [95:0] samp_mem [SD];
   logic [31:0] trd_ff;
   logic [95:0] srd_ff;
   logic [AW-1:0] taddr;
   logic [SW-1:0] saddr;
   logic          twe, swe;
   logic [SW-1:0] swaddr;

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] t_ff, t_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic [31:0] t1_ff, t1_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [JW-1:0] j_ff, j_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [31:0] d_ff, d_in;
   logic [FRAC_W-1:0] f_ff, f_in;
   logic [1:0]  mode_ff, mode_in;  // 0 lerp, 1 first record, 2 last record
   logic [95:0] a_ff, a_in;
   logic [1:0]  mcnt_ff, mcnt_in;
   logic        tsel_ff, tsel_in;  // which read in S_TLO and S_SRCH

   logic        rv_ff, rv_in;
   logic [JNT_W-1:0] rj_ff, rj_in;
   logic signed [31:0] ra_ff, ra_in, rvl_ff, rvl_in, rf_ff, rf_in;
   logic [IDX_W-1:0] rn_ff, rn_in;
   logic [1:0]  rs_ff, rs_in;
   logic        rl_ff, rl_in;

   logic signed [31:0] l_ang, l_vel, l_frc;
   logic [FRAC_W-1:0]  lf;
   logic [CW-1:0]      nm2;
   logic [32:0]        rem_sh;

   assign nm2 = count_ff - CW'(2);

   // Memory ports: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (twe) time_mem[taddr] <= req_stamp;
      trd_ff <= time_mem[taddr];
      if (swe) samp_mem[swaddr] <= {req_angle_in, req_velocity_in, req_force_in};
      srd_ff <= samp_mem[saddr];
   end

   // Three lanes share one multiplier form; the sequencer feeds one joint at a time.
   assign lf = (mode_ff == 2'd0) ? f_ff : '0;
   msi_lerp u_ang (.clock(clock), .a_val(a_ff[95:64]), .b_val(srd_ff[95:64]), .frac(lf),
                   .result(l_ang));
   msi_lerp u_vel (.clock(clock), .a_val(a_ff[63:32]), .b_val(srd_ff[63:32]), .frac(lf),
                   .result(l_vel));
   msi_lerp u_frc (.clock(clock), .a_val(a_ff[31:0]), .b_val(srd_ff[31:0]), .frac(lf),
                   .result(l_frc));

   assign rem_sh = {rem_ff[31:0], quo_ff[47]};

   // Sequencer.
   always_comb begin
      state_in = state_ff; count_in = count_ff; t_in = t_ff; t1_in = t1_ff;
      start_in = start_ff;
      lo_in = lo_ff; j_in = j_ff; dcnt_in = dcnt_ff; rem_in = rem_ff; quo_in = quo_ff;
      d_in = d_ff; f_in = f_ff; mode_in = mode_ff; a_in = a_ff; mcnt_in = mcnt_ff;
      tsel_in = tsel_ff;
      rv_in = rv_ff; rj_in = rj_ff; ra_in = ra_ff; rvl_in = rvl_ff; rf_in = rf_ff;
      rn_in = rn_ff; rs_in = rs_ff; rl_in = rl_ff;
      twe = 1'b0; swe = 1'b0;
      taddr = lo_ff[AW-1:0];
      swaddr = SW'(count_ff[AW-1:0] * JOINTS + req_joint);
      saddr = SW'(lo_ff * JOINTS + j_ff);
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !rv_ff;
            taddr = count_ff[AW-1:0];
            if (req_valid && !rv_ff) begin
               t_in = req_stamp;
               start_in = req_start_index;
               case (req_func)
                  FUNC_CLEAR: count_in = '0;
                  FUNC_PUSH: begin
                     if (req_joint < JNT_W'(JOINTS)) begin
                        if (count_ff >= CW'(TABLE_DEPTH)) begin
                           if (req_joint == JNT_W'(JOINTS - 1)) begin
                              rv_in = 1'b1; rj_in = '0; ra_in = '0; rvl_in = '0;
                              rf_in = '0; rn_in = '0; rs_in = STAT_FULL; rl_in = 1'b1;
                           end
                        end else begin
                           swe = 1'b1;
                           if (req_joint == JNT_W'(JOINTS - 1)) begin
                              twe = 1'b1;
                              count_in = count_ff + CW'(1);
                           end
                        end
                     end
                  end
                  FUNC_QUERY: begin
                     if (count_ff == '0) begin
                        rv_in = 1'b1; rj_in = '0; ra_in = '0; rvl_in = '0;
                        rf_in = '0; rn_in = '0; rs_in = STAT_EMPTY; rl_in = 1'b1;
                     end else begin
                        lo_in = '0;
                        state_in = S_T0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // Read first stamp.
         S_T0: begin
            taddr = '0;
            state_in = S_TREQ;
         end
         S_TREQ: begin
            taddr = AW'(count_ff - CW'(1));
            if (t_ff < trd_ff) begin
               mode_in = 2'd1; lo_in = '0; j_in = '0; state_in = S_RDB;
            end else state_in = S_TLAST;
         end
         S_TLAST: begin
            if (t_ff >= trd_ff) begin
               mode_in = 2'd2; lo_in = count_ff - CW'(1); j_in = '0; state_in = S_RDB;
            end else begin
               mode_in = 2'd0;
               lo_in = (CW'(start_ff) > nm2) ? nm2 : CW'(start_ff);
               tsel_in = 1'b0;
               state_in = S_TLO;
            end
         end
         // Check the start stamp, then walk forward.
         S_TLO: begin
            taddr = lo_ff[AW-1:0];
            if (!tsel_ff) tsel_in = 1'b1;
            else begin
               if (trd_ff > t_ff) lo_in = '0;
               state_in = S_SRCH;
               tsel_in = 1'b0;
            end
         end
         S_SRCH: begin
            // tsel 0: issue read of lo; then capture t1 and issue lo+1; then compare.
            if (!tsel_ff) begin
               taddr = lo_ff[AW-1:0];
               tsel_in = 1'b1;
               mcnt_in = 2'd0;
            end else if (mcnt_ff == 2'd0) begin
               t1_in = trd_ff;
               taddr = AW'(lo_ff + CW'(1));
               mcnt_in = 2'd1;
            end else begin
               if (lo_ff < nm2 && t_ff >= trd_ff) begin
                  lo_in = lo_ff + CW'(1);
                  t1_in = trd_ff;
                  taddr = AW'(lo_ff + CW'(2));
               end else begin
                  // Set up division of clamped n by d.
                  d_in = trd_ff - t1_ff;
                  rem_in = '0;
                  quo_in = {(t_ff > t1_ff) ?
                            ((t_ff - t1_ff > trd_ff - t1_ff) ? trd_ff - t1_ff
                                                             : t_ff - t1_ff) : 32'd0,
                            16'd0};
                  dcnt_in = 6'd48;
                  f_in = '0;
                  tsel_in = 1'b0;
                  state_in = (trd_ff > t1_ff) ? S_DIV : S_RDA;
                  j_in = '0;
               end
            end
         end
         // Restoring divider, one quotient bit per cycle.
         S_DIV: begin
            if (dcnt_ff == '0) begin
               f_in = (quo_ff[47:16] != '0) ? 16'hFFFF : quo_ff[15:0];
               state_in = S_RDA;
            end else begin
               if (rem_sh >= {1'b0, d_ff}) begin
                  rem_in = rem_sh - {1'b0, d_ff};
                  quo_in = {quo_ff[46:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[46:0], 1'b0};
               end
               dcnt_in = dcnt_ff - 6'd1;
            end
         end
         // Per joint: read lower sample, then upper (or same for end cases).
         S_RDA: begin
            saddr = SW'(lo_ff * JOINTS + j_ff);
            state_in = S_RDB;
            mode_in = 2'd0;
         end
         S_RDB: begin
            if (mode_ff == 2'd0) begin
               a_in = srd_ff;
               saddr = SW'((lo_ff + CW'(1)) * JOINTS + j_ff);
            end else begin
               saddr = SW'(lo_ff * JOINTS + j_ff);
               a_in = '0;
            end
            mcnt_in = 2'd0;
            state_in = S_MUL;
         end
         // Keep the upper sample on the read port while the lerp settles.
         S_MUL: begin
            if (mode_ff != 2'd0) a_in = srd_ff;
            else saddr = SW'((lo_ff + CW'(1)) * JOINTS + j_ff);
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd2) state_in = S_OUT;
         end
         S_OUT: begin
            if (mode_ff == 2'd0) saddr = SW'((lo_ff + CW'(1)) * JOINTS + j_ff);
            if (!rv_ff) begin
               rv_in = 1'b1; rj_in = JNT_W'(j_ff);
               ra_in = l_ang; rvl_in = l_vel; rf_in = l_frc;
               rn_in = (mode_ff == 2'd1) ? '0 :
                       (mode_ff == 2'd2) ? IDX_W'(count_ff) : IDX_W'(lo_ff);
               rs_in = STAT_OK;
               rl_in = (j_ff == JW'(JOINTS - 1));
               if (j_ff == JW'(JOINTS - 1)) state_in = S_IDLE;
               else begin
                  j_in = j_ff + JW'(1);
                  state_in = (mode_ff == 2'd0) ? S_RDA : S_RDB;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // In S_RDA the mode is lerp; end cases bypass it through S_RDB directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rv_ff <= 1'b0;
         tsel_ff <= 1'b0; mcnt_ff <= '0; dcnt_ff <= '0; mode_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rv_ff <= rv_in;
         tsel_ff <= tsel_in; mcnt_ff <= mcnt_in; dcnt_ff <= dcnt_in;
         mode_ff <= (state_ff == S_RDA && mode_ff != 2'd0) ? mode_ff : mode_in;
      end
      t_ff <= t_in; start_ff <= start_in; t1_ff <= t1_in; lo_ff <= lo_in; j_ff <= j_in;
      rem_ff <= rem_in; quo_ff <= quo_in; d_ff <= d_in; f_ff <= f_in; a_ff <= a_in;
      rj_ff <= rj_in; ra_ff <= ra_in; rvl_ff <= rvl_in; rf_ff <= rf_in;
      rn_ff <= rn_in; rs_ff <= rs_in; rl_ff <= rl_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_joint_out = rj_ff;
   assign rsp_angle_out = ra_ff;
   assign rsp_velocity_out = rvl_ff;
   assign rsp_force_out = rf_ff;
   assign rsp_next_index = rn_ff;
   assign rsp_status = rs_ff;
   assign rsp_last = rl_ff;
endmodule

// File: rtl/msi_checker.sv
// Port-level checker for the sample interpolator and its bind.
module msi_checker
   import msi_pkg::*;
(
   input logic clock, reset, req_valid, req_ready, rsp_valid, rsp_ready, rsp_last,
   input logic [1:0] rsp_status, input logic [JNT_W-1:0] rsp_joint_out
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp word dropped");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_last) else $error("error word not last");
   a_err_j: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_joint_out == '0) else $error("bad joint");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while word pending");
endmodule

bind multi_channel_sample_interpolator msi_checker u_msi_checker (.*);
